// ===== hdl/sid_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
package sid_pkg;

   localparam int MAG_WIDTH  = 32;
   localparam int NUM_DIGITS = 10;
   localparam int BIT_CNT_W  = $clog2(MAG_WIDTH);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   localparam logic [5:0] CHAR_MINUS = 6'd45;
   localparam logic [5:0] CHAR_ZERO  = 6'd48;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      logic clear;
      logic shift_bit;
      logic shift_digit;
   } cell_ctrl_type;

endpackage

// ===== hdl/sid_bcd_cell.sv =====
// One decimal digit cell: shift-add-3 step for binary input, digit shift for output.
module sid_bcd_cell (
   input  logic                   clock,
   input  sid_pkg::cell_ctrl_type ctrl,
   input  logic                   bit_in,
   input  sid_pkg::digit_type     digit_below,
   output logic                   bit_out,
   output sid_pkg::digit_type     digit_out
);

   sid_pkg::digit_type digit_ff;
   sid_pkg::digit_type digit_in;
   sid_pkg::digit_type adj;

   always_comb begin
      adj = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
      if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.shift_bit) begin
         digit_in = {adj[2:0], bit_in};
      end else if (ctrl.shift_digit) begin
         digit_in = digit_below;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign bit_out   = adj[3];
   assign digit_out = digit_ff;

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per word.
//
//  Channel | Ports                                                   | Direction
//  --------+---------------------------------------------------------+----------
//  request | req_valid, req_ready, req_value[31:0]                   | in
//  result  | rsp_valid, rsp_ready, rsp_char_code[5:0], rsp_last      | out
//
// An item is accepted, then its magnitude is shifted serially through a row of ten
// BCD digit cells, leading zero digits are dropped, and its characters are emitted
// one by one, the minus sign first when negative. Dropped zeros and emitted digits
// always total ten. Synchronous active-high reset returns the controller to idle and
// empties the output register. A stalled result holds the controller in its emit
// phase; the next item is taken while the final character still waits in the output
// register.
module signed_int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_char_code,
   output logic        rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } state_type;

   localparam int ND = sid_pkg::NUM_DIGITS;

   state_type                           state_ff, state_in;
   logic [sid_pkg::MAG_WIDTH-1:0]       mag_ff, mag_in;
   logic [sid_pkg::BIT_CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [sid_pkg::DIG_CNT_W-1:0]       remain_ff, remain_in;
   logic                                sign_ff, sign_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [5:0]                          rsp_char_ff, rsp_char_in;
   logic                                rsp_last_ff, rsp_last_in;

   sid_pkg::cell_ctrl_type              ctrl;
   logic                                bit_link   [ND];
   sid_pkg::digit_type                  digit_link [ND+1];
   sid_pkg::digit_type                  top_digit;
   logic                                accept;
   logic                                can_load;

   assign digit_link[0] = 4'd0;
   assign bit_link[0]   = mag_ff[sid_pkg::MAG_WIDTH-1];
   assign top_digit     = digit_link[ND];

   for (genvar i = 0; i < ND; i++) begin : g_cell
      if (i < ND - 1) begin : g_mid
         sid_bcd_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .bit_in     (bit_link[i]),
            .digit_below(digit_link[i]),
            .bit_out    (bit_link[i+1]),
            .digit_out  (digit_link[i+1])
         );
      end else begin : g_top
         sid_bcd_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .bit_in     (bit_link[i]),
            .digit_below(digit_link[i]),
            .bit_out    (),
            .digit_out  (digit_link[i+1])
         );
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign can_load  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bit_cnt_in   = bit_cnt_ff;
      remain_in    = remain_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sign_in    = req_value[31];
               mag_in     = req_value[31] ? (32'd0 - req_value) : req_value;
               bit_cnt_in = '0;
               remain_in  = sid_pkg::DIG_CNT_W'(sid_pkg::NUM_DIGITS);
               ctrl.clear = 1'b1;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            ctrl.shift_bit = 1'b1;
            mag_in         = {mag_ff[sid_pkg::MAG_WIDTH-2:0], 1'b0};
            bit_cnt_in     = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == sid_pkg::BIT_CNT_W'(sid_pkg::MAG_WIDTH - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((top_digit == 4'd0) && (remain_ff > sid_pkg::DIG_CNT_W'(1))) begin
               ctrl.shift_digit = 1'b1;
               remain_in        = remain_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = sid_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in      = sid_pkg::CHAR_ZERO + {2'b00, top_digit};
                  rsp_last_in      = (remain_ff == sid_pkg::DIG_CNT_W'(1));
                  ctrl.shift_digit = 1'b1;
                  remain_in        = remain_ff - 1'b1;
                  if (remain_ff == sid_pkg::DIG_CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      bit_cnt_ff  <= bit_cnt_in;
      remain_ff   <= remain_in;
      sign_ff     <= sign_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
